/* rtl/pcxrle_pkg.sv */
package pcxrle_pkg;

  // Fixed field widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 6;
  localparam int unsigned ColOutW = 9;
  localparam int unsigned RowOutW = 8;
  localparam int unsigned CfgW    = 9;
  localparam int unsigned CfgIdxW = 1;

  // Default grid limits.
  localparam int unsigned MaxWidthDefault  = 512;
  localparam int unsigned MaxHeightDefault = 256;

  // Reset values of the configuration registers.
  localparam logic [ColOutW-1:0] WidthResetVal  = 9'd319;
  localparam logic [RowOutW-1:0] HeightResetVal = 8'd199;

  // Run marker: two top bits set, low six bits are the length.
  localparam logic [1:0] RunMarkTag = 2'b11;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH_M1  = 1'b0,
    REG_HEIGHT_M1 = 1'b1
  } cfg_reg_e;

  // One queued request for the back end: a pixel value and its repeat count.
  typedef struct packed {
    logic [ByteW-1:0] value;
    logic [LenW-1:0]  len;
  } run_cmd_t;

  // Front-to-queue push.
  typedef struct packed {
    logic     valid;
    run_cmd_t cmd;
  } cmd_push_t;

  // Queue-to-back-end head.
  typedef struct packed {
    logic     valid;
    run_cmd_t cmd;
  } cmd_head_t;

endpackage

/* rtl/pcxrle_front.sv */
module pcxrle_front
  import pcxrle_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             queue_full_i,
  output cmd_push_t        push_o
);

  logic            awaiting_q, awaiting_d;
  logic [LenW-1:0] pend_len_q, pend_len_d;
  logic            accept;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  always_comb begin
    awaiting_d       = awaiting_q;
    pend_len_d       = pend_len_q;
    push_o.valid     = 1'b0;
    push_o.cmd.value = data_byte_i;
    push_o.cmd.len   = LenW'(1);
    if (accept) begin
      if (awaiting_q) begin
        // value byte of a run; an empty run is dropped here
        awaiting_d     = 1'b0;
        push_o.valid   = (pend_len_q != '0);
        push_o.cmd.len = pend_len_q;
      end else if (data_byte_i[ByteW-1 -: 2] == RunMarkTag) begin
        awaiting_d = 1'b1;
        pend_len_d = data_byte_i[LenW-1:0];
      end else begin
        push_o.valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      pend_len_q <= '0;
    end else begin
      awaiting_q <= awaiting_d;
      pend_len_q <= pend_len_d;
    end
  end

endmodule

/* rtl/pcxrle_cmd_fifo.sv */
module pcxrle_cmd_fifo
  import pcxrle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_push_t push_i,
  output logic      full_o,
  output cmd_head_t head_o,
  input  logic      pop_i
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  run_cmd_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == (PtrW+1)'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(do_push);
    rd_ptr_d = rd_ptr_q + PtrW'(do_pop);
    cnt_d    = cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* rtl/pcxrle_back.sv */
module pcxrle_back
  import pcxrle_pkg::*;
#(
  parameter int unsigned ColW = 9,
  parameter int unsigned RowW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [ColOutW-1:0] last_col_i,
  input  logic [RowOutW-1:0] last_row_i,
  input  cmd_head_t          head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ByteW-1:0]   pixel_value_o,
  output logic [ColOutW-1:0] column_o,
  output logic [RowOutW-1:0] row_o,
  output logic               last_in_run_o,
  output logic               image_done_o
);

  logic               active_q, active_d;
  logic [ByteW-1:0]   value_q, value_d;
  logic [LenW-1:0]    remain_q, remain_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic               finished_q, finished_d;

  logic               ov_q, ov_d;
  logic [ByteW-1:0]   opix_q;
  logic [ColOutW-1:0] ocol_q;
  logic [RowOutW-1:0] orow_q;
  logic               olast_q, odone_q;

  logic out_free, emit, row_end, done, pix_last, run_over, load;

  assign out_free = !ov_q || !out_stall_i;
  assign emit     = active_q && out_free;
  assign row_end  = (ColOutW'(col_q) >= last_col_i);
  assign done     = row_end && (RowOutW'(row_q) >= last_row_i);
  assign pix_last = (remain_q == LenW'(1)) || row_end;
  assign run_over = emit && pix_last;
  assign load     = head_i.valid && (!active_q || run_over);
  assign pop_o    = load;

  always_comb begin
    finished_d = finished_q || (emit && done);
    active_d   = active_q;
    value_d    = value_q;
    remain_d   = remain_q;
    col_d      = col_q;
    row_d      = row_q;
    if (emit) begin
      remain_d = remain_q - LenW'(1);
      if (row_end) begin
        col_d = '0;
        if (!done) begin
          row_d = row_q + RowW'(1);
        end
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
    if (load) begin
      // requests that arrive after the image is complete are discarded
      active_d = !finished_d;
      value_d  = head_i.cmd.value;
      remain_d = head_i.cmd.len;
    end else if (run_over) begin
      active_d = 1'b0;
    end
    ov_d = emit ? 1'b1 : (out_stall_i ? ov_q : 1'b0);
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      opix_q  <= value_q;
      ocol_q  <= ColOutW'(col_q);
      orow_q  <= RowOutW'(row_q);
      olast_q <= pix_last;
      odone_q <= done;
    end
    value_q  <= value_d;
    remain_q <= remain_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      finished_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      active_q   <= active_d;
      col_q      <= col_d;
      row_q      <= row_d;
      finished_q <= finished_d;
      ov_q       <= ov_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign pixel_value_o = opix_q;
  assign column_o      = ocol_q;
  assign row_o         = orow_q;
  assign last_in_run_o = olast_q;
  assign image_done_o  = odone_q;

endmodule

/* rtl/pcx_rle_decoder_unit.sv */
// PCX 8-bit run-length decoder. Bytes of the encoded image data enter on the
// in_* channel; a byte with both top bits set is a run marker whose low six
// bits give the length, and the byte after it is the value repeated that
// many times; any other byte is one pixel. Each pixel leaves on the out_*
// channel with its column and row, last_in_run_o on the last pixel a byte
// produces, and image_done_o on the pixel that closes the last row. A run
// that crosses the row end is cut there and the next row starts at column
// zero; an empty run produces nothing; once the image is complete every
// further byte is swallowed until reset. The front end classifies bytes and
// hands (value, length) requests to a two-entry queue; the back end places
// one pixel per clock, unless out_stall_i holds it, into an output register.
// A literal byte yields one pixel, a marker plus value pair up to 63; the
// queue lets bytes enter while a run is still placed, the back-end pixel
// loop being the bottleneck. Image size comes from cfg registers 0 (width
// minus one, reset 319) and 1 (height minus one, reset 199); the user must
// write them through cfg_we_i only while the block is idle, which the block
// does not enforce; both are further capped at MAX_WIDTH-1 and MAX_HEIGHT-1.
module pcx_rle_decoder_unit
  import pcxrle_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = MaxHeightDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  // encoded byte stream
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   data_byte_i,
  // decoded pixels
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ByteW-1:0]   pixel_value_o,
  output logic [ColOutW-1:0] column_o,
  output logic [RowOutW-1:0] row_o,
  output logic               last_in_run_o,
  output logic               image_done_o
);

  // The width and height registers bound the counters as well, so the
  // counters only need to span the smaller of the two limits.
  localparam int unsigned ColLim = (MAX_WIDTH < (1 << ColOutW)) ? MAX_WIDTH : (1 << ColOutW);
  localparam int unsigned RowLim = (MAX_HEIGHT < (1 << RowOutW)) ? MAX_HEIGHT
                                                                  : (1 << RowOutW);
  localparam int unsigned ColW   = (ColLim > 1) ? $clog2(ColLim) : 1;
  localparam int unsigned RowW   = (RowLim > 1) ? $clog2(RowLim) : 1;
  localparam logic [ColOutW-1:0] ColMax = ColOutW'(ColLim - 1);
  localparam logic [RowOutW-1:0] RowMax = RowOutW'(RowLim - 1);

  logic [ColOutW-1:0] width_q;
  logic [RowOutW-1:0] height_q;
  logic [ColOutW-1:0] last_col;
  logic [RowOutW-1:0] last_row;

  cmd_push_t push;
  cmd_head_t head;
  logic      q_full, pop;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthResetVal;
      height_q <= HeightResetVal;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WIDTH_M1:  width_q  <= cfg_data_i[ColOutW-1:0];
        REG_HEIGHT_M1: height_q <= cfg_data_i[RowOutW-1:0];
        default: ;
      endcase
    end
  end

  // effective last column / row
  assign last_col = (width_q > ColMax) ? ColMax : width_q;
  assign last_row = (height_q > RowMax) ? RowMax : height_q;

  pcxrle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .queue_full_i (q_full),
    .push_o       (push)
  );

  pcxrle_cmd_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  pcxrle_back #(
    .ColW (ColW),
    .RowW (RowW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .last_col_i    (last_col),
    .last_row_i    (last_row),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_value_o (pixel_value_o),
    .column_o      (column_o),
    .row_o         (row_o),
    .last_in_run_o (last_in_run_o),
    .image_done_o  (image_done_o)
  );

endmodule

/* rtl/pcxrle_checker.sv */
module pcxrle_checker
  import pcxrle_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [ByteW-1:0]   pixel_value_o,
  input logic [ColOutW-1:0] column_o,
  input logic [RowOutW-1:0] row_o,
  input logic               last_in_run_o,
  input logic               image_done_o
);

  logic out_take;
  logic done_seen_q;

  assign out_take = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_seen_q <= 1'b0;
    end else if (out_take && image_done_o) begin
      done_seen_q <= 1'b1;
    end
  end

  // stalled pixel holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(pixel_value_o)
      && $stable(column_o) && $stable(row_o) && $stable(last_in_run_o)
      && $stable(image_done_o)))
    else $error("stalled pixel changed");

  // image completion always ends the run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && image_done_o) |-> last_in_run_o)
    else $error("image_done without last_in_run");

  // nothing after the image is complete
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_seen_q |-> !out_valid_o)
    else $error("pixel after image done");

  // a run continues in the next column of the same row, without a gap
  a_run_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && !last_in_run_o) |=> (out_valid_o
      && (column_o == $past(column_o) + ColOutW'(1)) && (row_o == $past(row_o))
      && (pixel_value_o == $past(pixel_value_o))))
    else $error("run pixel out of sequence");

endmodule

bind pcx_rle_decoder_unit pcxrle_checker u_pcxrle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pixel_value_o (pixel_value_o),
  .column_o      (column_o),
  .row_o         (row_o),
  .last_in_run_o (last_in_run_o),
  .image_done_o  (image_done_o)
);
